// ----- sv/gfq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Grouped FIFO queue package
// Shared sizes, request and status codes, table entry and result types.
// ----------------------------------------------------------------------------
package gfq_pkg;

	localparam int NUM_ELEMENTS = 65536;
	localparam int NUM_GROUPS   = 1024;
	localparam int CAPACITY     = 1024;

	localparam int ELEM_W   = 16;
	localparam int GROUP_W  = 10;
	localparam int REQ_W    = 2;
	localparam int STATUS_W = 2;
	localparam int WAIT_W   = 11;
	localparam int COUNT_MAX = 2047;

	localparam int EA_W   = $clog2(NUM_ELEMENTS);
	localparam int GA_W   = $clog2(NUM_GROUPS);
	localparam int SLOT_W = $clog2(CAPACITY);
	localparam int FCNT_W = SLOT_W + 1;

	localparam int SWEEP_LEN_A = (NUM_ELEMENTS > NUM_GROUPS) ? NUM_ELEMENTS : NUM_GROUPS;
	localparam int SWEEP_LEN   = (SWEEP_LEN_A > CAPACITY) ? SWEEP_LEN_A : CAPACITY;
	localparam int SWEEP_W     = $clog2(SWEEP_LEN);

	localparam int IN_DATA_W  = ((ELEM_W + GROUP_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((ELEM_W + 7) / 8) * 8;
	localparam int OUT_USER_W = 1 + STATUS_W;

	typedef enum logic [REQ_W-1:0] {
		REQ_ASSIGN = 2'd0,
		REQ_ENQ    = 2'd1,
		REQ_DEQ    = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK    = 2'd0,
		STS_EMPTY = 2'd1,
		STS_FULL  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_ENQ_GRP,
		ST_ENQ_LINK,
		ST_ENQ_WR,
		ST_ENQ_FIX,
		ST_DEQ_MEM,
		ST_DEQ_GRP,
		ST_DEQ_WR,
		ST_RESP
	} state_t;

	typedef struct packed {
		status_t             status;
		logic [ELEM_W-1:0]   out_element;
		logic                has_value;
	} res_t;

	typedef struct packed {
		logic [WAIT_W-1:0] waiting;
		logic [SLOT_W-1:0] last;
	} grp_ent_t;

	function automatic logic elem_ok(input logic [ELEM_W-1:0] e);
		return {1'b0, e} < (ELEM_W + 1)'(NUM_ELEMENTS);
	endfunction

	function automatic logic grp_ok(input logic [GROUP_W-1:0] g);
		return {1'b0, g} < (GROUP_W + 1)'(NUM_GROUPS);
	endfunction

endpackage
`default_nettype wire

// ----- sv/gfq_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module gfq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- sv/gfq_out.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Grouped FIFO queue result register
// Holds one finished result until the downstream side takes it.
// ----------------------------------------------------------------------------
module gfq_out import gfq_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  wire res_t push_res,
	output logic      m_valid,
	input  wire logic m_ready,
	output res_t      m_res
);

	logic full_q;
	res_t res_q;

	assign push_ready = !full_q || m_ready;
	assign m_valid    = full_q;
	assign m_res      = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (push_valid && push_ready) begin
			full_q <= 1'b1;
		end else if (m_ready) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid && push_ready) begin
			res_q <= push_res;
		end
	end

endmodule
`default_nettype wire

// ----- sv/gfq_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Grouped FIFO queue engine
// Sequencer over the membership, linked-list, free-slot and group tables.
// ----------------------------------------------------------------------------
module gfq_core import gfq_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire req_t              in_req,
	input  wire logic [ELEM_W-1:0] in_elem,
	input  wire logic [GROUP_W-1:0] in_grp,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output res_t                   res
);

	state_t state_q, state_d;

	logic [SLOT_W-1:0]  head_q, head_d;
	logic [SLOT_W-1:0]  tail_q, tail_d;
	logic [FCNT_W-1:0]  len_q, len_d;
	logic [FCNT_W-1:0]  free_cnt_q, free_cnt_d;
	logic [SWEEP_W-1:0] sweep_q, sweep_d;
	logic               clr_resp_q, clr_resp_d;

	logic [ELEM_W-1:0]  elem_q, elem_d;
	logic [SLOT_W-1:0]  slot_q, slot_d;
	logic [GROUP_W-1:0] g_q, g_d;
	grp_ent_t           gent_q, gent_d;
	logic               grouped_q, grouped_d;
	res_t               res_q, res_d;

	logic               mem_we;
	logic [EA_W-1:0]    mem_waddr, mem_raddr;
	logic [GROUP_W-1:0] mem_wdata, mem_rd;

	logic               free_we;
	logic [SLOT_W-1:0]  free_waddr, free_wdata, free_raddr, free_rd;

	logic               nval_we;
	logic [SLOT_W-1:0]  nval_waddr;
	logic [ELEM_W-1:0]  nval_wdata, nval_rd;

	logic               nnext_we;
	logic [SLOT_W-1:0]  nnext_waddr, nnext_wdata, nnext_rd;
	logic [SLOT_W-1:0]  node_raddr;

	logic               grp_we;
	logic [GA_W-1:0]    grp_waddr, grp_raddr;
	grp_ent_t           grp_wdata, grp_rd;
	logic [$bits(grp_ent_t)-1:0] grp_rd_raw;

	logic [FCNT_W-1:0]  fcnt_dec;
	logic               sweep_in_cap, sweep_in_grp, sweep_last;

	assign fcnt_dec     = free_cnt_q - FCNT_W'(1);
	assign sweep_in_cap = {1'b0, sweep_q} < (SWEEP_W + 1)'(CAPACITY);
	assign sweep_in_grp = {1'b0, sweep_q} < (SWEEP_W + 1)'(NUM_GROUPS);
	assign sweep_last   = sweep_q == SWEEP_W'(SWEEP_LEN - 1);
	assign grp_rd       = grp_ent_t'(grp_rd_raw);

	assign in_ready  = state_q == ST_IDLE;
	assign res_valid = state_q == ST_RESP;
	assign res       = res_q;

	assign mem_raddr  = (state_q == ST_IDLE) ? in_elem[EA_W-1:0] : nval_rd[EA_W-1:0];
	assign free_raddr = fcnt_dec[SLOT_W-1:0];
	assign node_raddr = (state_q == ST_IDLE) ? head_q : grp_rd.last;
	assign grp_raddr  = mem_rd[GA_W-1:0];

	gfq_ram #(.WIDTH(GROUP_W), .DEPTH(NUM_ELEMENTS)) u_member (
		.clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rd)
	);

	gfq_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_free (
		.clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
		.raddr(free_raddr), .rdata(free_rd)
	);

	gfq_ram #(.WIDTH(ELEM_W), .DEPTH(CAPACITY)) u_node_val (
		.clk(clk), .we(nval_we), .waddr(nval_waddr), .wdata(nval_wdata),
		.raddr(node_raddr), .rdata(nval_rd)
	);

	gfq_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_node_next (
		.clk(clk), .we(nnext_we), .waddr(nnext_waddr), .wdata(nnext_wdata),
		.raddr(node_raddr), .rdata(nnext_rd)
	);

	gfq_ram #(.WIDTH($bits(grp_ent_t)), .DEPTH(NUM_GROUPS)) u_group (
		.clk(clk), .we(grp_we), .waddr(grp_waddr), .wdata(grp_wdata),
		.raddr(grp_raddr), .rdata(grp_rd_raw)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_SWEEP;
			head_q     <= '0;
			tail_q     <= '0;
			len_q      <= '0;
			free_cnt_q <= FCNT_W'(CAPACITY);
			sweep_q    <= '0;
			clr_resp_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			head_q     <= head_d;
			tail_q     <= tail_d;
			len_q      <= len_d;
			free_cnt_q <= free_cnt_d;
			sweep_q    <= sweep_d;
			clr_resp_q <= clr_resp_d;
		end
	end

	always_ff @(posedge clk) begin
		elem_q    <= elem_d;
		slot_q    <= slot_d;
		g_q       <= g_d;
		gent_q    <= gent_d;
		grouped_q <= grouped_d;
		res_q     <= res_d;
	end

	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		tail_d     = tail_q;
		len_d      = len_q;
		free_cnt_d = free_cnt_q;
		sweep_d    = sweep_q;
		clr_resp_d = clr_resp_q;
		elem_d     = elem_q;
		slot_d     = slot_q;
		g_d        = g_q;
		gent_d     = gent_q;
		grouped_d  = grouped_q;
		res_d      = res_q;

		mem_we      = 1'b0;
		mem_waddr   = sweep_q[EA_W-1:0];
		mem_wdata   = '0;
		free_we     = 1'b0;
		free_waddr  = sweep_q[SLOT_W-1:0];
		free_wdata  = sweep_q[SLOT_W-1:0];
		nval_we     = 1'b0;
		nval_waddr  = slot_q;
		nval_wdata  = elem_q;
		nnext_we    = 1'b0;
		nnext_waddr = slot_q;
		nnext_wdata = '0;
		grp_we      = 1'b0;
		grp_waddr   = sweep_q[GA_W-1:0];
		grp_wdata   = '0;

		case (state_q)
			ST_SWEEP: begin
				mem_we     = 1'b1;
				free_we    = sweep_in_cap;
				grp_we     = sweep_in_grp;
				head_d     = '0;
				tail_d     = '0;
				len_d      = '0;
				free_cnt_d = FCNT_W'(CAPACITY);
				sweep_d    = sweep_q + SWEEP_W'(1);
				if (sweep_last) begin
					res_d   = '{status: STS_OK, out_element: '0, has_value: 1'b0};
					state_d = clr_resp_q ? ST_RESP : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					elem_d = in_elem;
					res_d  = '{status: STS_OK, out_element: '0, has_value: 1'b0};
					case (in_req)
						REQ_ASSIGN: begin
							mem_we    = elem_ok(in_elem);
							mem_waddr = in_elem[EA_W-1:0];
							mem_wdata = in_grp;
							state_d   = ST_RESP;
						end
						REQ_ENQ: begin
							if (free_cnt_q == '0) begin
								res_d.status = STS_FULL;
								state_d      = ST_RESP;
							end else begin
								state_d = ST_ENQ_GRP;
							end
						end
						REQ_DEQ: begin
							if (len_q == '0) begin
								res_d.status = STS_EMPTY;
								state_d      = ST_RESP;
							end else begin
								state_d = ST_DEQ_MEM;
							end
						end
						REQ_CLEAR: begin
							sweep_d    = '0;
							clr_resp_d = 1'b1;
							state_d    = ST_SWEEP;
						end
						default: begin
							state_d = ST_RESP;
						end
					endcase
				end
			end
			ST_ENQ_GRP: begin
				slot_d  = free_rd;
				g_d     = (elem_ok(elem_q) && grp_ok(mem_rd)) ? mem_rd : '0;
				state_d = ST_ENQ_LINK;
			end
			ST_ENQ_LINK: begin
				gent_d    = grp_rd;
				grouped_d = (g_q != '0) && (grp_rd.waiting != '0) && (len_q != '0);
				state_d   = ST_ENQ_WR;
			end
			ST_ENQ_WR: begin
				nval_we     = 1'b1;
				nnext_we    = 1'b1;
				nnext_wdata = grouped_q ? nnext_rd : '0;
				grp_we      = g_q != '0;
				grp_waddr   = g_q[GA_W-1:0];
				grp_wdata.last    = slot_q;
				grp_wdata.waiting = (gent_q.waiting == WAIT_W'(COUNT_MAX)) ?
					gent_q.waiting : gent_q.waiting + WAIT_W'(1);
				free_cnt_d  = fcnt_dec;
				state_d     = ST_ENQ_FIX;
			end
			ST_ENQ_FIX: begin
				nnext_wdata = slot_q;
				if (grouped_q) begin
					nnext_we    = 1'b1;
					nnext_waddr = gent_q.last;
					if (gent_q.last == tail_q) begin
						tail_d = slot_q;
					end
				end else begin
					if (len_q == '0) begin
						head_d = slot_q;
					end else begin
						nnext_we    = 1'b1;
						nnext_waddr = tail_q;
					end
					tail_d = slot_q;
				end
				len_d   = len_q + FCNT_W'(1);
				state_d = ST_RESP;
			end
			ST_DEQ_MEM: begin
				elem_d     = nval_rd;
				free_we    = free_cnt_q < FCNT_W'(CAPACITY);
				free_waddr = free_cnt_q[SLOT_W-1:0];
				free_wdata = head_q;
				if (free_cnt_q < FCNT_W'(CAPACITY)) begin
					free_cnt_d = free_cnt_q + FCNT_W'(1);
				end
				len_d = len_q - FCNT_W'(1);
				if (len_q == FCNT_W'(1)) begin
					head_d = '0;
					tail_d = '0;
				end else begin
					head_d = nnext_rd;
				end
				state_d = ST_DEQ_GRP;
			end
			ST_DEQ_GRP: begin
				g_d     = (elem_ok(elem_q) && grp_ok(mem_rd)) ? mem_rd : '0;
				state_d = ST_DEQ_WR;
			end
			ST_DEQ_WR: begin
				grp_we    = (g_q != '0) && (grp_rd.waiting != '0);
				grp_waddr = g_q[GA_W-1:0];
				grp_wdata.last    = grp_rd.last;
				grp_wdata.waiting = grp_rd.waiting - WAIT_W'(1);
				res_d   = '{status: STS_OK, out_element: elem_q, has_value: 1'b1};
				state_d = ST_RESP;
			end
			ST_RESP: begin
				clr_resp_d = 1'b0;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- sv/grouped_fifo_queue_top.sv -----
// One request is worked on at a time; the next is taken once the result reaches the output
// register. After reset, and after every clear, a sweep over every table address zeroes
// the membership and group tables and refills the free-slot stack; no request is taken
// meanwhile.
`default_nettype none
// ----------------------------------------------------------------------------
// Grouped FIFO queue
// Team queue of element identifiers with group-aware insertion.
// ----------------------------------------------------------------------------
module grouped_fifo_queue_top import gfq_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,  // element_id, group_id, zero fill
	input  wire logic [REQ_W-1:0]      s_tuser,  // req_type
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,  // out_element
	output logic [OUT_USER_W-1:0]      m_tuser   // has_value, status
);

	logic res_valid, res_ready;
	res_t res_core, res_out;

	gfq_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_req(req_t'(s_tuser)),
		.in_elem(s_tdata[ELEM_W-1:0]),
		.in_grp(s_tdata[ELEM_W +: GROUP_W]),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res_core)
	);

	gfq_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(res_valid),
		.push_ready(res_ready),
		.push_res(res_core),
		.m_valid(m_tvalid),
		.m_ready(m_tready),
		.m_res(res_out)
	);

	assign m_tdata = OUT_DATA_W'(res_out.out_element);
	assign m_tuser = {res_out.status, res_out.has_value};

endmodule
`default_nettype wire

// ----- bench/grouped_fifo_queue_top_tb.sv -----
// ----------------------------------------------------------------------------
// Grouped FIFO queue testbench
// Drives assign, enqueue, dequeue and clear requests into the team queue with
// random gaps and back-pressure. A behavioural copy of the queue predicts each
// reply, and every reply is compared field by field in order of arrival.
// A short directed table comes first. Random traffic follows, in segments
// that lean towards filling, draining or a balanced mix.
// ----------------------------------------------------------------------------
module grouped_fifo_queue_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import gfq_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 300000;
	localparam int unsigned RANDOM_HALF    = 1000;
	localparam int unsigned PRINT_CAP      = 50;

	typedef enum int {MODE_MIX, MODE_FILL, MODE_DRAIN} traffic_t;

	typedef struct {
		req_t                kind;
		logic [ELEM_W-1:0]   elem;
		logic [GROUP_W-1:0]  grp;
		bit                  fixed;
		status_t             want;
	} step_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata = '0;
	logic [REQ_W-1:0]       s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic [OUT_USER_W-1:0]  m_tuser;

	bit [GROUP_W-1:0]  member_grp [NUM_ELEMENTS];
	bit [ELEM_W-1:0]   slot_elem [CAPACITY];
	bit [SLOT_W-1:0]   slot_link [CAPACITY];
	bit                slot_used [CAPACITY];
	bit [SLOT_W-1:0]   free_stack [CAPACITY];
	bit [SLOT_W-1:0]   grp_tail_slot [NUM_GROUPS];
	bit [WAIT_W-1:0]   grp_pending [NUM_GROUPS];
	int unsigned       free_depth;
	int unsigned       queue_len;
	bit [SLOT_W-1:0]   q_head;
	bit [SLOT_W-1:0]   q_tail;

	res_t         expected_replies [$];
	int unsigned  mismatches = 0;
	int unsigned  kind_count [4];
	int unsigned  full_refusals = 0;
	int unsigned  empty_refusals = 0;
	int unsigned  deepest_queue = 0;
	int unsigned  largest_count = 0;
	int unsigned  clears_left = 3;
	int unsigned  idle_cycles = 0;
	bit           no_idle = 1'b0;

	grouped_fifo_queue_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	function automatic void wipe_tables();
		for (int i = 0; i < NUM_ELEMENTS; i++)
			member_grp[i] = '0;
		for (int i = 0; i < NUM_GROUPS; i++)
			grp_pending[i] = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			free_stack[i] = SLOT_W'(i);
			slot_used[i] = 1'b0;
		end
		free_depth = CAPACITY;
		queue_len = 0;
		q_head = '0;
		q_tail = '0;
	endfunction

	function automatic logic [GROUP_W-1:0] group_of_elem(input logic [ELEM_W-1:0] e);
		logic [GROUP_W-1:0] g;
		g = member_grp[e];
		if (int'(e) >= NUM_ELEMENTS || int'(g) >= NUM_GROUPS)
			return '0;
		return g;
	endfunction

	function automatic res_t predict_team_queue(input req_t kind, input logic [ELEM_W-1:0] elem,
			input logic [GROUP_W-1:0] grp);
		res_t               res;
		bit [SLOT_W-1:0]    s;
		bit [SLOT_W-1:0]    last;
		logic [GROUP_W-1:0] eg;
		res = '0;
		res.status = STS_OK;
		kind_count[int'(kind)]++;
		case (kind)
			REQ_ASSIGN: begin
				if (int'(elem) < NUM_ELEMENTS)
					member_grp[elem] = grp;
			end
			REQ_ENQ: begin
				if (free_depth == 0) begin
					res.status = STS_FULL;
					full_refusals++;
				end else begin
					free_depth--;
					s = free_stack[free_depth];
					slot_elem[s] = elem;
					slot_link[s] = '0;
					slot_used[s] = 1'b1;
					eg = group_of_elem(elem);
					if (eg != 0 && grp_pending[eg] != 0 && queue_len != 0) begin
						last = grp_tail_slot[eg];
						slot_link[s] = slot_link[last];
						slot_link[last] = s;
						if (last == q_tail)
							q_tail = s;
					end else begin
						if (queue_len == 0)
							q_head = s;
						else
							slot_link[q_tail] = s;
						q_tail = s;
					end
					if (eg != 0) begin
						grp_tail_slot[eg] = s;
						if (grp_pending[eg] != WAIT_W'(COUNT_MAX))
							grp_pending[eg]++;
						if (grp_pending[eg] > largest_count)
							largest_count = grp_pending[eg];
					end
					queue_len++;
					if (queue_len > deepest_queue)
						deepest_queue = queue_len;
				end
			end
			REQ_DEQ: begin
				if (queue_len == 0) begin
					res.status = STS_EMPTY;
					empty_refusals++;
				end else begin
					s = q_head;
					res.out_element = slot_elem[s];
					res.has_value = 1'b1;
					eg = group_of_elem(slot_elem[s]);
					if (eg != 0 && grp_pending[eg] != 0)
						grp_pending[eg]--;
					q_head = slot_link[s];
					queue_len--;
					if (free_depth < CAPACITY) begin
						free_stack[free_depth] = s;
						free_depth++;
					end
					if (queue_len == 0) begin
						q_head = '0;
						q_tail = '0;
					end
				end
			end
			default: wipe_tables();
		endcase
		return res;
	endfunction

	function automatic logic [ELEM_W-1:0] rand_elem();
		if ($urandom_range(0, 4) == 0)
			return ELEM_W'($urandom_range(0, 65535));
		return ELEM_W'($urandom_range(0, 31));
	endfunction

	function automatic logic [GROUP_W-1:0] rand_grp();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return '0;
		if (roll < 8)
			return GROUP_W'($urandom_range(1, 7));
		return GROUP_W'($urandom_range(0, 1023));
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		if (mismatches < PRINT_CAP)
			$display("mismatch in %s at %0d ns: got %0h, expected %0h", what, $time, got, want);
		mismatches++;
	endtask

	task automatic issue_request(input req_t kind, input logic [ELEM_W-1:0] elem,
			input logic [GROUP_W-1:0] grp, input bit fixed = 1'b0,
			input status_t fixed_sts = STS_OK);
		int unsigned gap;
		res_t        predicted;
		gap = no_idle ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_DATA_W'({grp, elem});
		s_tuser  <= kind;
		do @(posedge clk); while (!s_tready);
		predicted = predict_team_queue(kind, elem, grp);
		if (fixed) begin
			predicted = '0;
			predicted.status = fixed_sts;
		end
		expected_replies.insert(expected_replies.size(), predicted);
	endtask

	// A dequeue must never reach a slot that has not been filled since the last clear,
	// so a damaged list is wiped instead.
	task automatic take_head();
		if (queue_len != 0 && !slot_used[q_head])
			issue_request(REQ_CLEAR, rand_elem(), rand_grp());
		else
			issue_request(REQ_DEQ, rand_elem(), rand_grp());
	endtask

	task automatic random_request(input traffic_t mode);
		int unsigned roll;
		int unsigned assign_cut;
		int unsigned enq_cut;
		roll = $urandom_range(0, 99);
		case (mode)
			MODE_FILL: begin
				assign_cut = 15;
				enq_cut = 90;
			end
			MODE_DRAIN: begin
				assign_cut = 10;
				enq_cut = 25;
			end
			default: begin
				assign_cut = 20;
				enq_cut = 62;
			end
		endcase
		if (clears_left != 0 && $urandom_range(0, 399) == 0) begin
			clears_left--;
			issue_request(REQ_CLEAR, rand_elem(), rand_grp());
		end else if (roll < assign_cut) begin
			issue_request(REQ_ASSIGN, rand_elem(), rand_grp());
		end else if (roll < enq_cut) begin
			issue_request(REQ_ENQ, rand_elem(), rand_grp());
		end else begin
			take_head();
		end
	endtask

	task automatic random_phase(input int unsigned count);
		int unsigned done_items;
		int unsigned seg_len;
		traffic_t    mode;
		done_items = 0;
		while (done_items < count) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: mode = MODE_MIX;
				5, 6, 7: mode = MODE_FILL;
				default: mode = MODE_DRAIN;
			endcase
			seg_len = $urandom_range(20, 150);
			no_idle = ($urandom_range(0, 3) == 0);
			repeat (seg_len) random_request(mode);
			done_items += seg_len;
		end
		no_idle = 1'b0;
	endtask

	initial begin
		step_t plan [$];
		wipe_tables();
		plan = '{
			'{REQ_DEQ,    16'h0000, 10'h000, 1'b1, STS_EMPTY},
			'{REQ_ASSIGN, 16'hFFFF, 10'h3FF, 1'b1, STS_OK},
			'{REQ_ASSIGN, 16'h0001, 10'h3FF, 1'b1, STS_OK},
			'{REQ_ASSIGN, 16'h0002, 10'h005, 1'b1, STS_OK},
			'{REQ_ENQ,    16'h0000, 10'h000, 1'b0, STS_OK},
			'{REQ_ENQ,    16'h0002, 10'h3FF, 1'b0, STS_OK},
			'{REQ_ENQ,    16'hFFFF, 10'h000, 1'b0, STS_OK},
			'{REQ_ENQ,    16'h0001, 10'h2AA, 1'b0, STS_OK},
			'{REQ_ENQ,    16'h0002, 10'h155, 1'b0, STS_OK},
			'{REQ_ASSIGN, 16'h0002, 10'h3FF, 1'b1, STS_OK},
			'{REQ_DEQ,    16'hFFFF, 10'h3FF, 1'b0, STS_OK},
			'{REQ_DEQ,    16'h0000, 10'h000, 1'b0, STS_OK},
			'{REQ_DEQ,    16'h5555, 10'h2AA, 1'b0, STS_OK},
			'{REQ_DEQ,    16'hAAAA, 10'h155, 1'b0, STS_OK},
			'{REQ_DEQ,    16'h0000, 10'h000, 1'b0, STS_OK},
			'{REQ_DEQ,    16'h0000, 10'h000, 1'b1, STS_EMPTY},
			'{REQ_ASSIGN, 16'h0003, 10'h005, 1'b1, STS_OK},
			'{REQ_ENQ,    16'h0003, 10'h000, 1'b0, STS_OK},
			'{REQ_ENQ,    16'h8000, 10'h000, 1'b0, STS_OK},
			'{REQ_ENQ,    16'h0003, 10'h000, 1'b0, STS_OK},
			'{REQ_ASSIGN, 16'h5555, 10'h2AA, 1'b1, STS_OK},
			'{REQ_CLEAR,  16'hFFFF, 10'h3FF, 1'b1, STS_OK},
			'{REQ_DEQ,    16'h0000, 10'h000, 1'b1, STS_EMPTY},
			'{REQ_ENQ,    16'hAAAA, 10'h155, 1'b0, STS_OK},
			'{REQ_DEQ,    16'h0000, 10'h000, 1'b0, STS_OK}
		};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		foreach (plan[i])
			issue_request(plan[i].kind, plan[i].elem, plan[i].grp, plan[i].fixed, plan[i].want);
		random_phase(RANDOM_HALF);
		random_phase(RANDOM_HALF);
		s_tvalid <= 1'b0;
		while (expected_replies.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Accepted %0d assign, %0d enqueue, %0d dequeue and %0d clear requests.",
			kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
		$display("Refused %0d on a full queue and %0d on an empty one; deepest queue %0d, %s %0d.",
			full_refusals, empty_refusals, deepest_queue, "largest group count",
			largest_count);
		if (mismatches == 0)
			$display("grouped_fifo_queue_top regression: pass");
		else
			$display("grouped_fifo_queue_top regression: fail");
		$finish;
	end

	initial begin
		int unsigned       stall;
		res_t              want;
		logic              got_has;
		logic [ELEM_W-1:0] got_elem;
		logic [1:0]        got_sts;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 19);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got_has = m_tuser[0];
			got_sts = m_tuser[2:1];
			got_elem = m_tdata[ELEM_W-1:0];
			if (expected_replies.size() == 0) begin
				report_mismatch("reply with no request outstanding", got_elem, 0);
			end else begin
				want = expected_replies[0];
				expected_replies.delete(0);
				if (got_has !== want.has_value)
					report_mismatch("has_value", got_has, want.has_value);
				if (got_elem !== want.out_element)
					report_mismatch("out_element", got_elem, want.out_element);
				if (got_sts !== want.status)
					report_mismatch("status", got_sts, want.status);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timed out after %0d cycles with no request or reply moving.", idle_cycles);
			$display("grouped_fifo_queue_top regression: fail");
			$finish;
		end
	end

endmodule

// ----- filelist.f -----
sv/gfq_pkg.sv
sv/gfq_ram.sv
sv/gfq_out.sv
sv/gfq_core.sv
sv/grouped_fifo_queue_top.sv
bench/grouped_fifo_queue_top_tb.sv
